// File: rtl/mfng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfng_pkg
// shared widths, hash constants and the job record passed from front to back
// ----------------------------------------------------------------------------
package mfng_pkg;

    localparam int LETTER_BITS     = 5;
    localparam int KEY_LETTERS     = 10;
    localparam int KEY_BITS        = 50;
    localparam int LEN_BITS        = 4;
    localparam int OUT_COUNT_BITS  = 20;
    localparam int SLOT_FIELD_BITS = 20;

    // hash arithmetic: h < HASH_MOD fits 20 bits, h*26+32 fits 25 bits
    localparam int HASH_BITS = 20;
    localparam int PROD_BITS = 25;
    localparam int RED_BITS  = 22;
    localparam logic [HASH_BITS-1:0] HASH_MOD   = 20'd999917;
    localparam logic [4:0]           HASH_RADIX = 5'd26;
    localparam logic [RED_BITS-1:0]  MOD_X1     = 22'd999917;
    localparam logic [RED_BITS-1:0]  MOD_X2     = 22'd1999834;

    typedef struct packed {
        logic [KEY_BITS-1:0]        key;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic                       count_it;
        logic                       last;
    } t_job;

endpackage

// File: rtl/mfng_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfng_ram
// simple dual-port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module mfng_ram #(
    parameter int WIDTH = 71,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// File: rtl/mfng_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfng_queue
// two-entry job queue between the front and the back
// ----------------------------------------------------------------------------
module mfng_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfng_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output mfng_pkg::t_job o_job,
    output logic           o_empty
);
    import mfng_pkg::*;

    t_job       r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_data[r_wptr] <= i_job;
                r_wptr         <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

// File: rtl/mfng_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfng_front
// letter window, gram length register, hash and home slot of each window
// ----------------------------------------------------------------------------
module mfng_front #(
    parameter int MAX_GRAM      = 10,
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mfng_pkg::LEN_BITS-1:0]    i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mfng_pkg::LETTER_BITS-1:0] i_letter,
    input  logic                             i_last_letter,
    output logic                             o_push,
    output mfng_pkg::t_job                   o_job,
    input  logic                             i_full
);
    import mfng_pkg::*;

    localparam int SLOT_W     = $clog2(TABLE_ENTRIES);
    localparam bit IS_POW2    = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_GRAM);
    // reciprocal of the table size, exact for every hash value below 2^HASH_BITS
    localparam int RECIP_SH   = HASH_BITS + SLOT_W;
    localparam int RECIP_BITS = HASH_BITS + 2;
    localparam int QP_W       = HASH_BITS + RECIP_BITS;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam logic [RECIP_BITS-1:0] RECIP  = RECIP_BITS'(RECIP_FULL);
    localparam logic [HASH_BITS-1:0]  N_HASH = HASH_BITS'(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL  = 6'b000010,
        F_RED  = 6'b000100,
        F_FIX  = 6'b001000,
        F_MOD  = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    t_fstate                r_state;
    logic [LETTER_BITS-1:0] r_win [MAX_GRAM];
    logic [LEN_BITS-1:0]    r_gram;
    logic [LEN_BITS-1:0]    r_fill;
    logic [LEN_BITS-1:0]    r_len;
    logic [LEN_BITS-1:0]    r_step;
    logic                   r_last;
    logic                   r_count;
    logic [HASH_BITS-1:0]   r_h;
    logic [PROD_BITS-1:0]   r_t;
    logic [RED_BITS-1:0]    r_r0;
    logic [HASH_BITS-1:0]   r_q;

    logic [LEN_BITS-1:0]    act_len;
    logic [LEN_BITS-1:0]    n_fill;
    logic [LETTER_BITS-1:0] cur_letter;
    logic [KEY_BITS-1:0]    key;
    logic [QP_W-1:0]        q_prod;
    logic [HASH_BITS-1:0]   h_rem;
    logic [HASH_BITS-1:0]   h_fixed;
    logic                   accept;

    assign o_ready = (r_state == F_IDLE);
    assign accept  = i_valid && o_ready;

    assign act_len = (r_gram == '0) ? LEN_BITS'(1) :
                     (r_gram > MAX_LEN) ? MAX_LEN : r_gram;
    assign n_fill  = (r_fill < MAX_LEN) ? r_fill + LEN_BITS'(1) : r_fill;

    // window letter for the current hash step, oldest of the gram first
    always_comb begin
        cur_letter = '0;
        for (int j = 0; j < MAX_GRAM; j++) begin
            if (j == MAX_GRAM - int'(r_len) + int'(r_step)) begin
                cur_letter = r_win[j];
            end
        end
    end

    // packed key, first letter lowest, letters past the key width dropped
    always_comb begin
        key = '0;
        for (int i = 0; i < KEY_LETTERS; i++) begin
            for (int j = 0; j < MAX_GRAM; j++) begin
                if ((i < int'(r_len)) && (j == MAX_GRAM - int'(r_len) + i)) begin
                    key[LETTER_BITS*i +: LETTER_BITS] = r_win[j];
                end
            end
        end
    end

    assign h_fixed = (r_r0 >= MOD_X2) ? HASH_BITS'(r_r0 - MOD_X2) :
                     (r_r0 >= MOD_X1) ? HASH_BITS'(r_r0 - MOD_X1) :
                     HASH_BITS'(r_r0);

    // quotient by reciprocal multiply, remainder from it the cycle after
    assign q_prod = QP_W'(r_h) * QP_W'(RECIP);
    assign h_rem  = r_h - HASH_BITS'(r_q * N_HASH);

    assign o_push        = (r_state == F_PUSH) && !i_full;
    assign o_job.key     = key;
    assign o_job.slot    = IS_POW2 ?
                           SLOT_FIELD_BITS'(r_h & HASH_BITS'(TABLE_ENTRIES - 1)) :
                           SLOT_FIELD_BITS'(h_rem);
    assign o_job.count_it = r_count;
    assign o_job.last     = r_last;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int j = 0; j < MAX_GRAM - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[MAX_GRAM-1] <= i_letter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_gram  <= LEN_BITS'(1);
            r_fill  <= '0;
            r_len   <= LEN_BITS'(1);
            r_step  <= '0;
            r_last  <= 1'b0;
            r_count <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gram <= i_cfg_wdata;
                r_fill <= '0;
            end
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_fill <= n_fill;
                        r_len  <= act_len;
                        r_last <= i_last_letter;
                        r_step <= '0;
                        r_h    <= '0;
                        if (n_fill >= act_len) begin
                            r_count <= 1'b1;
                            r_state <= F_MUL;
                        end else begin
                            r_count <= 1'b0;
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_MUL: begin
                    r_t <= PROD_BITS'(r_h) * PROD_BITS'(HASH_RADIX)
                           + PROD_BITS'(cur_letter) + PROD_BITS'(1);
                    r_state <= F_RED;
                end
                F_RED: begin
                    // top bits underestimate the quotient by at most two
                    r_r0 <= RED_BITS'(r_t - PROD_BITS'(PROD_BITS'(r_t[PROD_BITS-1:HASH_BITS])
                            * PROD_BITS'(HASH_MOD)));
                    r_state <= F_FIX;
                end
                F_FIX: begin
                    r_h <= h_fixed;
                    if (r_step == r_len - LEN_BITS'(1)) begin
                        r_state <= IS_POW2 ? F_PUSH : F_MOD;
                    end else begin
                        r_step  <= r_step + LEN_BITS'(1);
                        r_state <= F_MUL;
                    end
                end
                F_MOD: begin
                    r_q     <= HASH_BITS'(q_prod >> RECIP_SH);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        if (r_last) begin
                            r_fill <= '0;
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/mfng_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfng_back
// table probing, count update, best tracking, result register, table clearing
// ----------------------------------------------------------------------------
module mfng_back #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int COUNT_BITS    = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mfng_pkg::t_job                      i_job,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mfng_pkg::KEY_BITS-1:0]       o_best_gram,
    output logic [mfng_pkg::OUT_COUNT_BITS-1:0] o_best_count,
    output logic                                o_found,
    output logic                                o_table_overflow
);
    import mfng_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = 1 + KEY_BITS + COUNT_BITS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_LOOK  = 4'b0100,
        B_EMIT  = 4'b1000
    } t_bstate;

    t_bstate               r_state;
    t_job                  r_job;
    logic [SLOT_W-1:0]     r_addr;
    logic [SLOT_W-1:0]     r_probes;
    logic [SLOT_W-1:0]     r_clr;
    logic [KEY_BITS-1:0]   r_best_key;
    logic [COUNT_BITS-1:0] r_best_tally;
    logic                  r_ovf;

    logic                  we;
    logic [SLOT_W-1:0]     waddr;
    logic [WORD_W-1:0]     wdata;
    logic                  re;
    logic [SLOT_W-1:0]     raddr;
    logic [WORD_W-1:0]     rdata;
    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [SLOT_W-1:0]     next_addr;
    logic                  hit;
    logic                  emit;

    mfng_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_valid  = rdata[WORD_W-1];
    assign rd_key    = rdata[COUNT_BITS +: KEY_BITS];
    assign rd_cnt    = rdata[COUNT_BITS-1:0];
    assign next_addr = (r_addr == LAST_SLOT) ? '0 : r_addr + SLOT_W'(1);
    assign emit      = (r_state == B_EMIT) && (!o_valid || i_ready);

    always_comb begin
        we      = 1'b0;
        waddr   = r_addr;
        wdata   = '0;
        re      = 1'b0;
        raddr   = next_addr;
        o_pop   = 1'b0;
        hit     = 1'b0;
        new_cnt = COUNT_BITS'(1);
        unique case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
            end
            B_IDLE: begin
                o_pop = !i_empty;
                re    = !i_empty && i_job.count_it;
                raddr = SLOT_W'(i_job.slot);
            end
            B_LOOK: begin
                if (!rd_valid) begin
                    hit = 1'b1;
                end else if (rd_key == r_job.key) begin
                    hit     = 1'b1;
                    new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
                end else begin
                    re = (r_probes != LAST_SLOT);
                end
                we    = hit;
                wdata = {1'b1, r_job.key, new_cnt};
            end
            B_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_best_gram      <= r_best_key;
            o_best_count     <= OUT_COUNT_BITS'(r_best_tally);
            o_found          <= (r_best_tally != '0);
            o_table_overflow <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_CLEAR;
            r_clr        <= '0;
            r_best_key   <= '0;
            r_best_tally <= '0;
            r_ovf        <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    if (r_clr == LAST_SLOT) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_clr <= r_clr + SLOT_W'(1);
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job    <= i_job;
                        r_addr   <= SLOT_W'(i_job.slot);
                        r_probes <= '0;
                        if (i_job.count_it) begin
                            r_state <= B_LOOK;
                        end else if (i_job.last) begin
                            r_state <= B_EMIT;
                        end
                    end
                end
                B_LOOK: begin
                    if (hit) begin
                        // strictly greater keeps the earlier key on a tie
                        if ((r_best_tally == '0) || (new_cnt > r_best_tally)) begin
                            r_best_tally <= new_cnt;
                            r_best_key   <= r_job.key;
                        end
                        r_state <= r_job.last ? B_EMIT : B_IDLE;
                    end else if (r_probes == LAST_SLOT) begin
                        r_ovf   <= 1'b1;
                        r_state <= r_job.last ? B_EMIT : B_IDLE;
                    end else begin
                        r_addr   <= next_addr;
                        r_probes <= r_probes + SLOT_W'(1);
                    end
                end
                B_EMIT: begin
                    if (emit) begin
                        r_best_key   <= '0;
                        r_best_tally <= '0;
                        r_ovf        <= 1'b0;
                        r_clr        <= '0;
                        r_state      <= B_CLEAR;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/most_frequent_ngram_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// most_frequent_ngram_counter
// counts substrings of a letter stream and reports the most frequent one
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready carry one letter item and its last flag
// output channel: o_valid / i_ready carry one result item per string, after
// the item flagged last; i_cfg_we writes the gram length: the user must write
// it only while idle, the block does not enforce this
// front: takes a letter, then hashes the gram with a multiply, a reduce and
// a fix step per letter, plus a reciprocal multiply if TABLE_ENTRIES is not a
// power of two, then pushes the job into the two-entry queue
// back: issues the read, then probes the table ram one slot after another
// (one read port, registered read); the front runs ahead of the back by
// up to two queued items
// after reset and after each result the back sweeps the table clearing one
// entry a cycle; meanwhile the queue fills and o_ready drops
// a result waits in the output register while i_ready is low; the back
// holds the next result until the register is free
// ----------------------------------------------------------------------------
module most_frequent_ngram_counter #(
    parameter int MAX_GRAM      = 10,
    parameter int TABLE_ENTRIES = 4096,
    parameter int COUNT_BITS    = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mfng_pkg::LEN_BITS-1:0]       i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [mfng_pkg::LETTER_BITS-1:0]    i_letter,
    input  logic                                i_last_letter,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mfng_pkg::KEY_BITS-1:0]       o_best_gram,
    output logic [mfng_pkg::OUT_COUNT_BITS-1:0] o_best_count,
    output logic                                o_found,
    output logic                                o_table_overflow
);
    import mfng_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic full;
    logic pop;
    logic empty;

    mfng_front #(
        .MAX_GRAM      (MAX_GRAM),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .o_push        (push),
        .o_job         (push_job),
        .i_full        (full)
    );

    mfng_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    mfng_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (head_job),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_best_gram      (o_best_gram),
        .o_best_count     (o_best_count),
        .o_found          (o_found),
        .o_table_overflow (o_table_overflow)
    );
endmodule

// File: rtl/mfng_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfng_checker
// port-level checks on the result and letter channels, bound to the top level
// ----------------------------------------------------------------------------
module mfng_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [mfng_pkg::KEY_BITS-1:0]       o_best_gram,
    input logic [mfng_pkg::OUT_COUNT_BITS-1:0] o_best_count,
    input logic                                o_found,
    input logic                                o_table_overflow
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_best_gram) &&
        $stable(o_best_count) && $stable(o_found) && $stable(o_table_overflow))
        else $error("result changed while stalled");

    // no window seen means an empty result
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_best_count == '0) && (o_best_gram == '0))
        else $error("empty result carries data");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_best_count != '0))
        else $error("found with zero count");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result straight after reset");

    // a waiting letter item stays offered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("letter item withdrawn while waiting");
endmodule

bind most_frequent_ngram_counter mfng_checker u_mfng_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_best_gram      (o_best_gram),
    .o_best_count     (o_best_count),
    .o_found          (o_found),
    .o_table_overflow (o_table_overflow)
);

// File: tb/most_frequent_ngram_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// most_frequent_ngram_counter_tb
// streams letter strings under several gram lengths and checks every
// reported best substring, count, found and overflow flag against a
// cycle-free software copy of the counter kept alongside the stimulus
// ----------------------------------------------------------------------------
module most_frequent_ngram_counter_tb;

    import mfng_pkg::*;

    localparam int MAX_GRAM      = 10;
    localparam int TABLE_ENTRIES = 4096;
    localparam int COUNT_BITS    = 20;
    localparam int IDLE_PCT      = 14;
    localparam int SETTLE_CYCLES = 5000;
    localparam int HOLD_CYCLES   = 20000;
    localparam int QUIET_FROM    = 30000;
    localparam int QUIET_TO      = 60000;
    localparam int RANDOM_ITEMS  = 950;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef struct {
        logic [LETTER_BITS-1:0] letter;
        logic                   last;
    } letter_item_t;

    typedef struct {
        logic [KEY_BITS-1:0]       gram;
        logic [OUT_COUNT_BITS-1:0] count;
        logic                      found;
        logic                      overflow;
    } ngram_result_t;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [LEN_BITS-1:0]         i_cfg_wdata;
    logic                        i_valid;
    logic                        o_ready;
    logic [LETTER_BITS-1:0]      i_letter;
    logic                        i_last_letter;
    logic                        o_valid;
    logic                        i_ready;
    logic [KEY_BITS-1:0]         o_best_gram;
    logic [OUT_COUNT_BITS-1:0]   o_best_count;
    logic                        o_found;
    logic                        o_table_overflow;

    most_frequent_ngram_counter #(
        .MAX_GRAM      (MAX_GRAM),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_letter         (i_letter),
        .i_last_letter    (i_last_letter),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_best_gram      (o_best_gram),
        .o_best_count     (o_best_count),
        .o_found          (o_found),
        .o_table_overflow (o_table_overflow)
    );

    letter_item_t  letter_q[$];
    ngram_result_t best_q[$];

    // software copy of the counter
    logic [LEN_BITS-1:0]    gram_reg;
    logic [LETTER_BITS-1:0] win[MAX_GRAM];
    int                     win_fill;
    bit                     tab_valid[TABLE_ENTRIES];
    logic [KEY_BITS-1:0]    tab_key[TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]  tab_cnt[TABLE_ENTRIES];
    logic [KEY_BITS-1:0]    best_key;
    logic [COUNT_BITS-1:0]  best_cnt;
    bit                     ovf_flag;

    int  errors;
    int  cycle_cnt;
    int  hold_ask;
    int  strings_seen;
    int  not_found_seen;
    int  overflow_seen;
    int  letters_sent;
    bit  in_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit idle_roll();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic count_window(input int len);
        int                  h;
        int                  slot;
        int                  probes;
        logic [KEY_BITS-1:0] key;
        logic [4:0]          c;
        h   = 0;
        key = '0;
        for (int i = 0; i < len; i++) begin
            c   = win[MAX_GRAM - len + i];
            h   = (h * 26 + int'(c) + 1) % 999917;
            key = key | (KEY_BITS'(c) << (5 * i));
        end
        slot = h % TABLE_ENTRIES;
        for (probes = 0; probes < TABLE_ENTRIES; probes++) begin
            if (!tab_valid[slot]) begin
                tab_valid[slot] = 1'b1;
                tab_key[slot]   = key;
                tab_cnt[slot]   = 1;
                break;
            end
            if (tab_key[slot] == key) begin
                if (tab_cnt[slot] != COUNT_TOP)
                    tab_cnt[slot]++;
                break;
            end
            slot = (slot + 1) % TABLE_ENTRIES;
        end
        if (probes == TABLE_ENTRIES) begin
            ovf_flag = 1'b1;
            return;
        end
        if (best_cnt == 0 || tab_cnt[slot] > best_cnt) begin
            best_cnt = tab_cnt[slot];
            best_key = key;
        end
    endtask

    // queue one letter and work out what the counter should report
    task automatic send_letter(input logic [LETTER_BITS-1:0] letter, input logic last);
        int            len;
        ngram_result_t r;
        len = (gram_reg == 0) ? 1 : (gram_reg > MAX_GRAM) ? MAX_GRAM : int'(gram_reg);
        for (int i = 0; i < MAX_GRAM - 1; i++)
            win[i] = win[i + 1];
        win[MAX_GRAM - 1] = letter;
        if (win_fill < MAX_GRAM)
            win_fill++;
        if (win_fill >= len)
            count_window(len);
        letter_q.push_back('{letter: letter, last: last});
        letters_sent++;
        if (last) begin
            r.gram     = best_key;
            r.count    = best_cnt;
            r.found    = best_cnt != 0;
            r.overflow = ovf_flag;
            best_q.push_back(r);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tab_valid[i] = 1'b0;
            win_fill = 0;
            best_key = '0;
            best_cnt = '0;
            ovf_flag = 1'b0;
        end
    endtask

    task automatic send_string(input int n, input int alphabet, input bit wide);
        logic [LETTER_BITS-1:0] c;
        for (int i = 0; i < n; i++) begin
            c = wide ? LETTER_BITS'($urandom_range(31))
                     : LETTER_BITS'($urandom_range(alphabet - 1));
            send_letter(c, i == n - 1);
        end
    endtask

    // block must be quiet before the gram length changes
    task automatic write_gram(input logic [LEN_BITS-1:0] value);
        wait (letter_q.size() == 0 && best_q.size() == 0);
        @(posedge i_clk);
        wait (!i_valid);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gram_reg = value;
        win_fill = 0;
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_taken  <= i_valid && o_ready;
    end

    // letter driver
    always @(negedge i_clk) begin : drv
        letter_item_t it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (letter_q.size() > 0 && !idle_roll()) begin
                it = letter_q.pop_front();
                i_valid       <= 1'b1;
                i_letter      <= it.letter;
                i_last_letter <= it.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge i_clk) begin : rcv
        static int hold_left = 0;
        static int hold_seen = 0;
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !idle_roll();
        end
    end

    always @(posedge i_clk) begin : mon
        ngram_result_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (best_q.size() == 0) begin
                $display("%0t: unexpected item gram=%h count=%0d found=%b ovf=%b", $time,
                         o_best_gram, o_best_count, o_found, o_table_overflow);
                errors++;
            end else begin
                e = best_q.pop_front();
                strings_seen++;
                if (!e.found) not_found_seen++;
                if (e.overflow) overflow_seen++;
                if (o_best_gram !== e.gram) begin
                    $display("%0t: best_gram expected %h actual %h", $time, e.gram, o_best_gram);
                    errors++;
                end
                if (o_best_count !== e.count) begin
                    $display("%0t: best_count expected %0d actual %0d", $time, e.count,
                             o_best_count);
                    errors++;
                end
                if (o_found !== e.found) begin
                    $display("%0t: found expected %b actual %b", $time, e.found, o_found);
                    errors++;
                end
                if (o_table_overflow !== e.overflow) begin
                    $display("%0t: table_overflow expected %b actual %b", $time, e.overflow,
                             o_table_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("most_frequent_ngram_counter test failed");
        $finish;
    end

    initial begin : stim
        int n;
        int g;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_letter      = '0;
        i_last_letter = 1'b0;
        i_ready       = 1'b0;
        errors = 0; cycle_cnt = 0; hold_ask = 0; in_taken = 1'b0;
        strings_seen = 0; not_found_seen = 0; overflow_seen = 0; letters_sent = 0;
        gram_reg = 1; win_fill = 0; best_key = '0; best_cnt = '0;
        ovf_flag = 1'b0;
        for (int i = 0; i < MAX_GRAM; i++) win[i] = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) tab_valid[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single letter, ties keep the earlier key, code extremes
        write_gram(4'd1);
        send_letter(5'd0, 1'b1);
        send_letter(5'd1, 1'b0); send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b0); send_letter(5'd0, 1'b1);
        send_letter(5'd31, 1'b0); send_letter(5'd26, 1'b0); send_letter(5'd31, 1'b1);
        // string shorter than the window
        write_gram(4'd10);
        send_string(5, 26, 1'b0);
        send_letter(5'd31, 1'b0);
        for (int i = 0; i < 9; i++) send_letter(5'd31, i == 8);
        // zero and oversize lengths
        write_gram(4'd0);
        send_string(6, 3, 1'b0);
        write_gram(4'd15);
        send_string(12, 2, 1'b0);
        // change of length mid-string keeps the table
        write_gram(4'd2);
        send_letter(5'd3, 1'b0); send_letter(5'd4, 1'b0); send_letter(5'd3, 1'b0);
        write_gram(4'd3);
        send_letter(5'd4, 1'b0); send_letter(5'd3, 1'b0); send_letter(5'd4, 1'b1);

        // random strings, mostly small alphabets so that counts build up
        n = 0;
        while (n < RANDOM_ITEMS) begin
            g = $urandom_range(11);
            write_gram(g == 11 ? 4'(10 + $urandom_range(5)) : 4'(g));
            if (n > RANDOM_ITEMS / 3 && hold_ask == 0)
                hold_ask++;
            for (int s = 0; s < 6; s++) begin
                g = $urandom_range(1, 40);
                send_string(g, $urandom_range(1, 4), $urandom_range(5) == 0);
                n += g;
            end
        end

        wait (letter_q.size() == 0 && best_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d letters, checked %0d strings (%0d with no full window, %0d overflowed)",
                 letters_sent, strings_seen, not_found_seen, overflow_seen);
        if (errors == 0)
            $display("most_frequent_ngram_counter test passed");
        else
            $display("most_frequent_ngram_counter test failed");
        $finish;
    end

endmodule
